// ===== rtl/core/dqr_pkg.sv =====
// shared types and codes of the ring-buffer double-ended queue
`default_nettype none
package dqr_pkg;

   localparam int DataW = 32;
   localparam int OccW  = 8;

   localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
   localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [1:0] MODE_POP_BACK   = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [DataW-1:0] data_in;
   } dqr_req_type;

   typedef struct packed {
      logic [DataW-1:0] data_out;
      logic [1:0]       status;
      logic [OccW-1:0]  occupancy;
   } dqr_rsp_type;

   // response load request from the controller to the output register
   typedef struct packed {
      logic            load;
      logic            use_rd;
      logic [1:0]      status;
      logic [OccW-1:0] occupancy;
   } dqr_rsp_ctl_type;

   typedef enum logic {
      DQR_IDLE,
      DQR_POP_WAIT
   } dqr_state_type;

endpackage
`default_nettype wire

// ===== rtl/core/dqr_ram.sv =====
// single-port item store with registered read data
`default_nettype none
module dqr_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem_ff[addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dqr_ctrl.sv =====
// pointer, count and sequencing control of the queue
`default_nettype none
module dqr_ctrl #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire dqr_pkg::dqr_req_type      req,
   output logic                           busy,
   output logic                           mem_we,
   output logic                           mem_re,
   output logic      [$clog2(DEPTH)-1:0]  mem_addr,
   output logic      [WIDTH-1:0]          mem_wdata,
   output dqr_pkg::dqr_rsp_ctl_type       rsp_ctl
);
   import dqr_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   dqr_state_type   state_ff, state_in;
   logic [PtrW-1:0] front_ff, front_in, back_ff, back_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] front_up, front_dn, back_up, back_dn;
   logic            accept, full, empty, is_pop, pop_ok;

   assign accept = start && (state_ff == DQR_IDLE);
   assign full   = (count_ff == CntW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign is_pop = (req.mode == MODE_POP_FRONT) || (req.mode == MODE_POP_BACK);
   assign pop_ok = accept && is_pop && !empty;

   assign front_up = (front_ff == PtrW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;
   assign front_dn = (front_ff == '0) ? PtrW'(DEPTH - 1) : front_ff - 1'b1;
   assign back_up  = (back_ff == PtrW'(DEPTH - 1)) ? '0 : back_ff + 1'b1;
   assign back_dn  = (back_ff == '0) ? PtrW'(DEPTH - 1) : back_ff - 1'b1;

   assign mem_wdata = req.data_in[WIDTH-1:0];

   // pointer and count update, memory access
   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_addr = front_ff;
      if (accept) begin
         unique case (req.mode)
            MODE_PUSH_FRONT: begin
               if (!full) begin
                  front_in = front_dn;
                  mem_addr = front_dn;
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_PUSH_BACK: begin
               if (!full) begin
                  back_in  = back_up;
                  mem_addr = back_ff;
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_POP_FRONT: begin
               if (!empty) begin
                  front_in = front_up;
                  mem_addr = front_ff;
                  mem_re   = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            MODE_POP_BACK: begin
               if (!empty) begin
                  back_in  = back_dn;
                  mem_addr = back_dn;
                  mem_re   = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DQR_IDLE:     if (pop_ok) state_in = DQR_POP_WAIT;
         DQR_POP_WAIT: state_in = DQR_IDLE;
         default:      state_in = DQR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy              = 1'b0;
      rsp_ctl.load      = 1'b0;
      rsp_ctl.use_rd    = 1'b0;
      rsp_ctl.status    = STATUS_DONE;
      rsp_ctl.occupancy = OccW'(count_in);
      unique case (state_ff)
         DQR_IDLE: begin
            if (accept && !pop_ok) begin
               rsp_ctl.load = 1'b1;
               if (is_pop) begin
                  rsp_ctl.status = STATUS_EMPTY;
               end else if (full) begin
                  rsp_ctl.status = STATUS_FULL;
               end
            end
         end
         DQR_POP_WAIT: begin
            busy              = 1'b1;
            rsp_ctl.load      = 1'b1;
            rsp_ctl.use_rd    = 1'b1;
            rsp_ctl.occupancy = OccW'(count_ff);
         end
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DQR_IDLE;
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/double_ended_queue_ring.sv =====
// top level of the ring-buffer double-ended queue
// response: a push or a refused request answers in the cycle after start; a pop answers
// after the store read register and then the response register; throughput: pushes and
// refused requests one per cycle while busy is low, held off while a pop reads the store
// reset: synchronous, empties the queue and clears both pointers; store contents stay
// the receiver cannot stall: each response is shown for one cycle on rsp_strobe
`default_nettype none
module double_ended_queue_ring #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire dqr_pkg::dqr_req_type req_payload,
   output logic                      rsp_strobe,
   output dqr_pkg::dqr_rsp_type      rsp_payload
);
   import dqr_pkg::*;

   // items wider than the result field could never be returned, so store at most that
   localparam int StoreW = (DATA_WIDTH < DataW) ? DATA_WIDTH : DataW;
   localparam int PtrW   = $clog2(DEPTH);

   logic              mem_we, mem_re;
   logic [PtrW-1:0]   mem_addr;
   logic [StoreW-1:0] mem_wdata, mem_rdata;
   dqr_rsp_ctl_type   rsp_ctl;

   logic              rsp_strobe_ff;
   dqr_rsp_type       rsp_ff, rsp_in;

   // controller: pointers, occupancy and the pop read wait
   dqr_ctrl #(
      .DEPTH (DEPTH),
      .WIDTH (StoreW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_payload),
      .busy      (busy),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rsp_ctl   (rsp_ctl)
   );

   // item store, one access per cycle
   dqr_ram #(
      .DEPTH (DEPTH),
      .WIDTH (StoreW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // response assembly: popped data comes straight from the store read register,
   // every other transaction reports zero data
   always_comb begin
      rsp_in.data_out  = rsp_ctl.use_rd ? DataW'(mem_rdata) : '0;
      rsp_in.status    = rsp_ctl.status;
      rsp_in.occupancy = rsp_ctl.occupancy;
   end

   // strobe is control state; payload register loads only with a response
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_ctl.load;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench of the ring-buffer double-ended queue
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dqr_pkg::*;

   localparam int Depth      = 128;
   localparam int PtrW       = $clog2(Depth);
   localparam int CycleLimit = 200_000;
   // margin after the last owed result, so any straggler response is still caught
   localparam int DrainCycles = 8;
   localparam int RandomItems = 620;
   localparam int NumRows     = 24;

   // one row of the directed table; typed rows carry their own expected result
   typedef struct {
      logic [1:0]       mode;
      logic [DataW-1:0] data;
      int               reps;
      bit               typed;
      logic [DataW-1:0] exp_data;
      logic [1:0]       exp_status;
      logic [OccW-1:0]  exp_occ;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   dqr_req_type req_payload;
   logic        rsp_strobe;
   dqr_rsp_type rsp_payload;

   // shadow copy of the queue contents and pointers
   logic [DataW-1:0] ring_mem [Depth];
   logic [PtrW-1:0]  ring_front;
   logic [PtrW-1:0]  ring_back;
   int               ring_count;

   // results still owed by the block, oldest first
   dqr_rsp_type expected_rsp_q [$];

   // expectation override for the transaction currently on the request port
   bit          item_typed;
   dqr_rsp_type item_typed_rsp;

   int mismatch_count;
   int cycle_count;
   int burst_left;

   dqr_rsp_type got_rsp;
   dqr_rsp_type want_rsp;

   stim_row_type stim_table [NumRows] = '{
      // pops on an empty queue straight after reset, data field ignored
      '{MODE_POP_FRONT,  32'h0000_0000, 1, 1'b1, 32'h0, STATUS_EMPTY, 8'd0},
      '{MODE_POP_BACK,   32'hFFFF_FFFF, 1, 1'b1, 32'h0, STATUS_EMPTY, 8'd0},
      // single item in and out again, the last item comes back
      '{MODE_PUSH_BACK,  32'hFFFF_FFFF, 1, 1'b1, 32'h0, STATUS_DONE, 8'd1},
      '{MODE_POP_FRONT,  32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF, STATUS_DONE, 8'd0},
      // push at the front, taken out again from the back
      '{MODE_PUSH_FRONT, 32'h0000_0000, 1, 1'b1, 32'h0, STATUS_DONE, 8'd1},
      '{MODE_POP_BACK,   32'hFFFF_FFFF, 1, 1'b1, 32'h0, STATUS_DONE, 8'd0},
      // mixed ends
      '{MODE_PUSH_FRONT, 32'hA5A5_A5A5, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_PUSH_FRONT, 32'h5A5A_5A5A, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_PUSH_BACK,  32'h1234_5678, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_POP_FRONT,  32'h0000_0000, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_POP_BACK,   32'h0000_0000, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_PUSH_BACK,  32'hDEAD_BEEF, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_POP_FRONT,  32'h0000_0000, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_POP_FRONT,  32'h0000_0000, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_POP_BACK,   32'h0000_0000, 1, 1'b1, 32'h0, STATUS_EMPTY, 8'd0},
      // fill through the back, then pushes at both ends are refused
      '{MODE_PUSH_BACK,  32'h0000_0001, Depth, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b1, 32'h0, STATUS_FULL, 8'd128},
      '{MODE_PUSH_BACK,  32'h0000_0000, 1, 1'b1, 32'h0, STATUS_FULL, 8'd128},
      // pop front hands out the oldest back push
      '{MODE_POP_FRONT,  32'h0000_0000, 1, 1'b1, 32'h1, STATUS_DONE, 8'd127},
      '{MODE_PUSH_FRONT, 32'h8000_0000, 1, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1'b1, 32'h0, STATUS_FULL, 8'd128},
      // drain through the back, then both pops refused
      '{MODE_POP_BACK,   32'h0000_0000, Depth, 1'b0, 32'h0, STATUS_DONE, 8'd0},
      '{MODE_POP_FRONT,  32'h0000_0000, 1, 1'b1, 32'h0, STATUS_EMPTY, 8'd0},
      '{MODE_POP_BACK,   32'h0000_0000, 1, 1'b1, 32'h0, STATUS_EMPTY, 8'd0}
   };

   double_ended_queue_ring #(
      .DEPTH      (Depth),
      .DATA_WIDTH (DataW)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // applies one request to the shadow queue and returns the result it earns
   function automatic dqr_rsp_type deque_predict(input dqr_req_type req);
      dqr_rsp_type r;
      r.data_out = '0;
      r.status   = STATUS_DONE;
      case (req.mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (ring_count >= Depth) begin
               // full: item dropped, nothing moves
               r.status = STATUS_FULL;
            end else if (req.mode == MODE_PUSH_FRONT) begin
               ring_front           = ring_front - 1'b1;
               ring_mem[ring_front] = req.data_in;
               ring_count++;
            end else begin
               ring_mem[ring_back] = req.data_in;
               ring_back           = ring_back + 1'b1;
               ring_count++;
            end
         end
         default: begin
            if (ring_count == 0) begin
               // empty: nothing moves, data stays zero
               r.status = STATUS_EMPTY;
            end else if (req.mode == MODE_POP_FRONT) begin
               r.data_out = ring_mem[ring_front];
               ring_front = ring_front + 1'b1;
               ring_count--;
            end else begin
               ring_back  = ring_back - 1'b1;
               r.data_out = ring_mem[ring_back];
               ring_count--;
            end
         end
      endcase
      r.occupancy = OccW'(ring_count);
      return r;
   endfunction

   // one transaction: drive at the falling edge, hold until accepted
   task automatic send_request(input dqr_req_type req, input bit typed,
                               input dqr_rsp_type typed_rsp);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         // idle gap between bursts, request port carries noise meanwhile
         start       = 1'b0;
         req_payload = $bits(dqr_req_type)'({$urandom, $urandom});
         gap         = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         // now and then a long stretch with no idling at all
         if ($urandom_range(0, 5) == 0)
            burst_left = $urandom_range(60, 200);
         else
            burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      start          = 1'b1;
      req_payload    = req;
      item_typed     = typed;
      item_typed_rsp = typed_rsp;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // response checker and predictor, all on the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         // check first: a result never belongs to a transaction taken at the same edge
         if (rsp_strobe) begin
            got_rsp = rsp_payload;
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response data_out=%h status=%0d occupancy=%0d",
                      got_rsp.data_out, got_rsp.status, got_rsp.occupancy);
               mismatch_count++;
            end else begin
               want_rsp = expected_rsp_q[0];
               expected_rsp_q.delete(0);
               if (got_rsp.data_out !== want_rsp.data_out) begin
                  $error("data_out expected %h actual %h", want_rsp.data_out,
                         got_rsp.data_out);
                  mismatch_count++;
               end
               if (got_rsp.status !== want_rsp.status) begin
                  $error("status expected %0d actual %0d", want_rsp.status,
                         got_rsp.status);
                  mismatch_count++;
               end
               if (got_rsp.occupancy !== want_rsp.occupancy) begin
                  $error("occupancy expected %0d actual %0d", want_rsp.occupancy,
                         got_rsp.occupancy);
                  mismatch_count++;
               end
            end
         end
         // accepted transaction: the prediction always runs, also for typed rows, so the shadow state stays in step
         if (start && !busy) begin
            want_rsp = deque_predict(req_payload);
            expected_rsp_q.insert(expected_rsp_q.size(),
                                  item_typed ? item_typed_rsp : want_rsp);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      dqr_req_type req;
      dqr_rsp_type typed_rsp;
      int push_pct;
      int seg_left;
      int pick;

      reset          = 1'b1;
      start          = 1'b0;
      req_payload    = '0;
      item_typed     = 1'b0;
      item_typed_rsp = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      burst_left     = 0;
      ring_front     = '0;
      ring_back      = '0;
      ring_count     = 0;
      for (int i = 0; i < Depth; i++)
         ring_mem[i] = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, repeated rows step the data by one per transaction
      foreach (stim_table[r]) begin
         for (int k = 0; k < stim_table[r].reps; k++) begin
            req.mode            = stim_table[r].mode;
            req.data_in         = stim_table[r].data + DataW'(k);
            typed_rsp.data_out  = stim_table[r].exp_data;
            typed_rsp.status    = stim_table[r].exp_status;
            typed_rsp.occupancy = stim_table[r].exp_occ;
            send_request(req, stim_table[r].typed, typed_rsp);
         end
      end

      // random part: segments leaning to pushes, to pops, or balanced, so the
      // queue swings between full and empty and both pointers wrap many times
      typed_rsp = '0;
      seg_left  = 0;
      push_pct  = 50;
      for (int n = 0; n < RandomItems; n++) begin
         if (seg_left == 0) begin
            pick     = $urandom_range(0, 2);
            push_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
            seg_left = $urandom_range(20, 260);
         end
         seg_left--;
         if ($urandom_range(0, 99) < push_pct)
            req.mode = ($urandom_range(0, 1) == 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
         else
            req.mode = ($urandom_range(0, 1) == 0) ? MODE_POP_FRONT : MODE_POP_BACK;
         pick = $urandom_range(0, 15);
         if (pick == 0)
            req.data_in = '0;
         else if (pick == 1)
            req.data_in = '1;
         else
            req.data_in = $urandom;
         send_request(req, 1'b0, typed_rsp);
      end

      @(negedge clock);
      start = 1'b0;

      // wait for every owed result, then a drain margin for anything extra
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
`default_nettype wire
